// File: hdl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg: types and codes of the stack machine execute unit
// Opcodes, error codes, word types of both channels and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package smeu_pkg;

  localparam logic [4:0] OP_INPP = 5'd0;
  localparam logic [4:0] OP_CRCT = 5'd1;
  localparam logic [4:0] OP_SOMA = 5'd2;
  localparam logic [4:0] OP_SUBT = 5'd3;
  localparam logic [4:0] OP_MULT = 5'd4;
  localparam logic [4:0] OP_DIVI = 5'd5;
  localparam logic [4:0] OP_INVR = 5'd6;
  localparam logic [4:0] OP_CONJ = 5'd7;
  localparam logic [4:0] OP_DISJ = 5'd8;
  localparam logic [4:0] OP_NEGA = 5'd9;
  localparam logic [4:0] OP_CMME = 5'd10;
  localparam logic [4:0] OP_CMMA = 5'd11;
  localparam logic [4:0] OP_CMIG = 5'd12;
  localparam logic [4:0] OP_CMDG = 5'd13;
  localparam logic [4:0] OP_CMEG = 5'd14;
  localparam logic [4:0] OP_CMAG = 5'd15;
  localparam logic [4:0] OP_DSVS = 5'd16;
  localparam logic [4:0] OP_DSVF = 5'd17;
  localparam logic [4:0] OP_NADA = 5'd18;
  localparam logic [4:0] OP_PARA = 5'd19;
  localparam logic [4:0] OP_CRVL = 5'd20;
  localparam logic [4:0] OP_ARMZ = 5'd21;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_SLOT  = 3'd4;

  typedef struct packed {
    logic [4:0]         func;
    logic signed [31:0] constant_value;
    logic [5:0]         slot_address;
    logic [15:0]        jump_target;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [15:0]        next_pc;
    logic               halted;
    logic               last;
    logic [2:0]         status_code;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for an instruction
    ST_READ,   // operand reads in flight
    ST_EXEC,   // operands registered, work out result
    ST_DIV,    // iterative divider running
    ST_WRITE,  // write back and fetch new top
    ST_TOP,    // new top returned from memory
    ST_DUMP,   // halt dump, builds the word of one entry
    ST_OUT     // result word waiting for the receiver
  } state_t;

endpackage
`default_nettype wire

// File: hdl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit: executes decoded stack machine instructions
//
// Each input word carries one decoded instruction; the unit answers with one
// result word (top of stack, next pc, flags, error), or during a halt with one
// word per stack entry from bottom to top, the final one marked last.
// The stack lives in a single-port-write, two-read synchronous memory with
// registered read data. A plain instruction raises out_valid after operand
// read, execute, write back, top re-read and output load. Division runs
// the one-bit-a-step divider between execute and write back. A halt dump
// builds each word after the receiver has taken the one before it; an
// instruction ignored while halted answers with no write back.
// The next instruction is taken once the last result word has left the
// output register. A stalled receiver simply holds the output register.
// Reset (rst_n low at a clock edge) empties the stack, clears the program
// counter, the halt flag and the reset word; the memory is not cleared, as
// only entries below the stack count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int PC_BITS     = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  smeu_pkg::in_word_t      in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output smeu_pkg::out_word_t     out_data,
  input  wire                     cfg_we,
  input  wire  [31:0]             cfg_data
);
  import smeu_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // Stack memory
  logic [31:0] mem [STACK_DEPTH];
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]   wdata, rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // Architectural and sequencer registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  logic          halt_r, halt_nxt;
  logic [31:0]   rst_val_r;
  in_word_t      ins_r;
  logic [31:0]   res_r, res_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [PC_BITS-1:0] npc_r, npc_nxt;
  logic [CW-1:0] dump_r, dump_nxt;
  out_word_t     out_r, out_nxt;
  logic          ov_r, ov_nxt;
  logic          more_r, more_nxt;
  logic          fwd_r, fwd_nxt;
  // Divider
  logic [31:0]   dq_r, dq_nxt, drem_r, drem_nxt, dd_r, dd_nxt;
  logic [5:0]    dn_r, dn_nxt;
  logic          dneg_r, dneg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      rst_val_r <= '0;
      ov_r      <= 1'b0;
      more_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      ov_r    <= ov_nxt;
      more_r  <= more_nxt;
      if (cfg_we) begin
        rst_val_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ins_r <= in_data;
    end
    res_r  <= res_nxt;
    err_r  <= err_nxt;
    npc_r  <= npc_nxt;
    dump_r <= dump_nxt;
    out_r  <= out_nxt;
    fwd_r  <= fwd_nxt;
    dq_r   <= dq_nxt;
    drem_r <= drem_nxt;
    dd_r   <= dd_nxt;
    dn_r   <= dn_nxt;
    dneg_r <= dneg_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Operand decode on the registered instruction
  logic [4:0] f;
  logic is_bin, is_un, is_push;
  assign f       = ins_r.func;
  assign is_push = (f == OP_CRCT) || (f == OP_CRVL);
  assign is_bin  = (f >= OP_SOMA) && (f <= OP_CMAG) && (f != OP_INVR) && (f != OP_NEGA);
  assign is_un   = (f == OP_INVR) || (f == OP_NEGA);

  logic signed [31:0] sa, sb;
  logic [31:0] mul_p;
  assign sa    = rd_a;
  assign sb    = rd_b;
  assign mul_p = rd_a * rd_b;

  logic slot_ok;
  assign slot_ok = 32'(ins_r.slot_address) < 32'(cnt_r);

  // Divider step: restoring, one quotient bit a cycle on magnitudes
  logic [32:0] dtrial;
  logic [31:0] dshift;
  assign dshift = {drem_r[30:0], dq_r[31]};
  assign dtrial = {1'b0, dshift} - {1'b0, dd_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_ready) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (f == OP_INPP) state_nxt = ST_WRITE;
        else if (halt_r) state_nxt = ST_OUT;
        else if (f == OP_PARA) state_nxt = ST_DUMP;
        else if (f == OP_DIVI && cnt_r >= CW'(2) && rd_b != 0) state_nxt = ST_DIV;
        else state_nxt = ST_WRITE;
      end
      ST_DIV:   if (dn_r == 6'd31) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_TOP;
      ST_TOP:   state_nxt = ST_OUT;
      ST_DUMP:  state_nxt = ST_OUT;
      ST_OUT: begin
        // Leave only once the held word has been taken
        if (ov_r && out_ready) state_nxt = more_r ? ST_DUMP : ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [31:0] qv;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr_a   = '0;
    raddr_b   = '0;
    cnt_nxt   = cnt_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    npc_nxt   = npc_r;
    dump_nxt  = dump_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r;
    more_nxt  = more_r;
    fwd_nxt   = 1'b0;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    dd_nxt    = dd_r;
    dn_nxt    = dn_r;
    dneg_nxt  = dneg_r;
    qv        = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_READ: begin
        // Read next-to-top and top, or the slot for a load
        raddr_a = AW'(cnt_r - CW'(2));
        raddr_b = AW'(cnt_r - CW'(1));
        if (f == OP_CRVL) raddr_a = AW'(ins_r.slot_address);
      end
      ST_EXEC: begin
        err_nxt = ERR_OK;
        npc_nxt = pc_r + PC_BITS'(1);
        res_nxt = '0;
        if (f == OP_INPP) begin
          we = 1'b1; waddr = '0; wdata = rst_val_r;
          cnt_nxt = CW'(1); halt_nxt = 1'b0; npc_nxt = PC_BITS'(1);
          raddr_b = '0;
        end else if (halt_r) begin
          out_nxt = '{result_value: (cnt_r == 0) ? '0 : rd_b,
                      next_pc: 16'(pc_r), halted: 1'b1, last: 1'b1, status_code: ERR_OK};
          more_nxt = 1'b0;
        end else if (f == OP_PARA) begin
          halt_nxt = 1'b1;
          dump_nxt = '0;
          raddr_a = '0;
        end else if (is_push) begin
          if (cnt_r >= DEPTH_C) err_nxt = ERR_OVER;
          else if (f == OP_CRVL && !slot_ok) err_nxt = ERR_SLOT;
          else res_nxt = (f == OP_CRCT) ? ins_r.constant_value : rd_a;
        end else if (is_bin) begin
          if (cnt_r < CW'(2)) err_nxt = ERR_UNDER;
          else begin
            unique case (f)
              OP_SOMA: res_nxt = rd_a + rd_b;
              OP_SUBT: res_nxt = rd_a - rd_b;
              OP_MULT: res_nxt = mul_p;
              OP_DIVI: begin
                if (rd_b == 0) err_nxt = ERR_DIV0;
                dq_nxt   = sa[31] ? -rd_a : rd_a;
                dd_nxt   = sb[31] ? -rd_b : rd_b;
                drem_nxt = '0;
                dn_nxt   = '0;
                dneg_nxt = sa[31] ^ sb[31];
              end
              OP_CONJ: res_nxt = 32'((rd_a == 1) && (rd_b == 1));
              OP_DISJ: res_nxt = 32'((rd_a == 1) || (rd_b == 1));
              OP_CMME: res_nxt = 32'(sa < sb);
              OP_CMMA: res_nxt = 32'(sa > sb);
              OP_CMIG: res_nxt = 32'(sa == sb);
              OP_CMDG: res_nxt = 32'(sa != sb);
              OP_CMEG: res_nxt = 32'(sa <= sb);
              default: res_nxt = 32'(sa >= sb);
            endcase
          end
        end else if (is_un || f == OP_DSVF || f == OP_ARMZ) begin
          if (cnt_r < CW'(1)) err_nxt = ERR_UNDER;
          else if (f == OP_ARMZ && !slot_ok) err_nxt = ERR_SLOT;
          else if (f == OP_INVR) res_nxt = -rd_b;
          else if (f == OP_NEGA) res_nxt = 32'd1 - rd_b;
          else if (f == OP_ARMZ) res_nxt = rd_b;
          else if (rd_b == 0) npc_nxt = PC_BITS'(ins_r.jump_target);
        end else if (f == OP_DSVS) begin
          npc_nxt = PC_BITS'(ins_r.jump_target);
        end
      end
      ST_DIV: begin
        if (dtrial[32]) begin
          drem_nxt = dshift;
          dq_nxt   = {dq_r[30:0], 1'b0};
        end else begin
          drem_nxt = dtrial[31:0];
          dq_nxt   = {dq_r[30:0], 1'b1};
        end
        dn_nxt = dn_r + 6'd1;
        if (dn_r == 6'd31) begin
          qv = dq_nxt;
          res_nxt = dneg_r ? -qv : qv;
        end
      end
      ST_WRITE: begin
        pc_nxt = npc_r;
        if (err_r == ERR_OK) begin
          if (is_push) begin
            we = 1'b1; waddr = AW'(cnt_r); wdata = res_r; cnt_nxt = cnt_r + CW'(1);
          end else if (is_bin) begin
            we = 1'b1; waddr = AW'(cnt_r - CW'(2)); wdata = res_r;
            cnt_nxt = cnt_r - CW'(1);
          end else if (is_un) begin
            we = 1'b1; waddr = AW'(cnt_r - CW'(1)); wdata = res_r;
          end else if (f == OP_ARMZ) begin
            we = 1'b1; waddr = AW'(ins_r.slot_address); wdata = res_r;
            cnt_nxt = cnt_r - CW'(1);
          end else if (f == OP_DSVF) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        raddr_b = AW'(cnt_nxt - CW'(1));
        // The memory returns the old word when the new top is written now
        fwd_nxt = we && (waddr == raddr_b);
      end
      ST_TOP: begin
        if (f == OP_INPP) pc_nxt = npc_r;
        out_nxt = '{result_value: (cnt_r == 0) ? '0 : (fwd_r ? res_r : rd_b),
                    next_pc: 16'(pc_nxt),
                    halted: 1'b0, last: 1'b1, status_code: err_r};
        more_nxt = 1'b0;
      end
      ST_DUMP: begin
        out_nxt = '{result_value: (cnt_r == 0) ? '0 : rd_a, next_pc: 16'(pc_r),
                    halted: 1'b1, last: (dump_r + CW'(1) >= cnt_r), status_code: ERR_OK};
        more_nxt = (dump_r + CW'(1) < cnt_r);
        dump_nxt = dump_r + CW'(1);
      end
      ST_OUT: begin
        raddr_a = AW'(dump_r);
        if (!ov_r) ov_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    // A freshly built word enters the output register on the way to ST_OUT
    if (state_r == ST_OUT && !ov_r) ov_nxt = 1'b1;
  end

endmodule
`default_nettype wire

// File: hdl/smeu_checker.sv
// ----------------------------------------------------------------------------
// smeu_checker: port-level checks for the stack machine execute unit
// Watches the two channels and flags ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input smeu_pkg::out_word_t  out_data
);
  import smeu_pkg::*;

  // A held result word does not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // No new instruction is taken while a result waits.
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("instruction accepted while result pending");

  // Only a halt dump gives a word that is not last.
  a_lasthalt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.halted)
    else $error("non-final word outside a halt dump");

  // An accepted instruction yields no result in the very next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind stack_machine_execute_unit smeu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
